// ----- rtl/fi_pkg.sv -----
// fi_pkg: shared sizes, field codes and command structs of the fir interpolator
// depends on nothing; used by every module of the block
package fi_pkg;

    // array sizes
    localparam int MAX_TAPS   = 64;
    localparam int MAX_FACTOR = 8;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int TAP_W      = 18;
    localparam int TIDX_W     = 6;
    localparam int KIND_W     = 2;
    localparam int FRAC_BITS  = 15;

    // derived widths
    localparam int PROD_W     = SAMPLE_W + TAP_W;
    localparam int ACC_W      = PROD_W + $clog2(MAX_TAPS);
    localparam int IDX_W      = $clog2(MAX_TAPS);
    localparam int TAPS_W     = $clog2(MAX_TAPS + 1);
    localparam int MAX_DELAY  = (MAX_TAPS - 1) / 2;
    localparam int DROP_W     = $clog2(MAX_DELAY + 2);
    localparam int MAX_SLOTS  = (MAX_FACTOR > MAX_DELAY) ? MAX_FACTOR : MAX_DELAY;
    localparam int SLOT_W     = $clog2(MAX_SLOTS + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN  = 2'd2;

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TAP    = 2'd2;

    // commands to the cell row
    typedef struct packed {
        logic shift;
        logic rotate;
        logic clear;
    } cell_cmd_t;

    // commands to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic step;
        logic use_tap;
    } mac_cmd_t;

endpackage

// ----- rtl/fi_cell.sv -----
// fi_cell: one cell of the ring, holds one history sample and one tap
// depends on fi_pkg
module fi_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fi_pkg::cell_cmd_t               cmd,
    input  logic                            tap_we,
    input  logic signed [fi_pkg::TAP_W-1:0] tap_wdata,
    input  logic signed [fi_pkg::SAMPLE_W-1:0] hist_left,
    input  logic signed [fi_pkg::SAMPLE_W-1:0] hist_right,
    input  logic signed [fi_pkg::TAP_W-1:0] tap_right,
    output logic signed [fi_pkg::SAMPLE_W-1:0] hist,
    output logic signed [fi_pkg::TAP_W-1:0] tap
);
    import fi_pkg::*;

    logic signed [SAMPLE_W-1:0] hist_reg, hist_next;
    logic signed [TAP_W-1:0]    tap_reg, tap_next;

    // clear the sample, shift in from the newer side, rotate toward the head, or write the tap
    always_comb
    begin
        hist_next = hist_reg;
        tap_next  = tap_reg;
        priority if (cmd.clear)
        begin
            hist_next = '0;
        end
        else if (cmd.shift)
        begin
            hist_next = hist_left;
        end
        else if (cmd.rotate)
        begin
            hist_next = hist_right;
            tap_next  = tap_right;
        end
        else if (tap_we)
        begin
            tap_next = tap_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            tap_reg  <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
            tap_reg  <= tap_next;
        end
    end

    assign hist = hist_reg;
    assign tap  = tap_reg;

endmodule

// ----- rtl/fi_mac.sv -----
// fi_mac: head multiplier, accumulator and q1.15 round and saturate
// depends on fi_pkg
module fi_mac (
    input  logic                               clk,
    input  fi_pkg::mac_cmd_t                   cmd,
    input  logic signed [fi_pkg::SAMPLE_W-1:0] hist,
    input  logic signed [fi_pkg::TAP_W-1:0]    tap,
    output logic signed [fi_pkg::SAMPLE_W-1:0] result
);
    import fi_pkg::*;

    localparam int Q_W = ACC_W + 1 - FRAC_BITS;
    localparam logic signed [ACC_W:0]  RND_HALF = (ACC_W+1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [Q_W-1:0]  Q_MAX = Q_W'((1 <<< (SAMPLE_W - 1)) - 1);
    localparam logic signed [Q_W-1:0]  Q_MIN = -Q_W'(1 <<< (SAMPLE_W - 1));

    logic signed [PROD_W-1:0] prod_reg, prod_next, prod_full;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W:0]    rnd;
    logic signed [Q_W-1:0]    q;

    assign prod_full = hist * tap;

    // the registered product is added to the accumulator in the cycle after it is formed
    always_comb
    begin
        prod_next = prod_reg;
        acc_next  = acc_reg;
        priority if (cmd.clear)
        begin
            prod_next = '0;
            acc_next  = '0;
        end
        else if (cmd.step)
        begin
            prod_next = cmd.use_tap ? prod_full : '0;
            acc_next  = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // round half up, then saturate
    always_comb
    begin
        rnd = (ACC_W+1)'(acc_reg) + RND_HALF;
        q   = Q_W'(rnd >>> FRAC_BITS);
        priority if (q > Q_MAX)
        begin
            result = SAMPLE_W'(Q_MAX);
        end
        else if (q < Q_MIN)
        begin
            result = SAMPLE_W'(Q_MIN);
        end
        else
        begin
            result = SAMPLE_W'(q);
        end
    end

endmodule

// ----- rtl/fi_ctrl.sv -----
// fi_ctrl: item sequencer, configuration registers, drop count and output register
// depends on fi_pkg
module fi_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [fi_pkg::KIND_W-1:0]          kind,
    input  logic signed [fi_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                               cfg_we,
    input  logic [fi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fi_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [fi_pkg::SAMPLE_W-1:0] mac_result,
    output fi_pkg::cell_cmd_t                  cell_cmd,
    output fi_pkg::mac_cmd_t                   mac_cmd,
    output logic signed [fi_pkg::SAMPLE_W-1:0] slot_value,
    output logic                               tap_wr,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [fi_pkg::SAMPLE_W-1:0] sample_out,
    output logic                               last_of_run,
    output logic                               end_of_block
);
    import fi_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SHIFT = 6'b000010,
        S_MAC   = 6'b000100,
        S_SUM   = 6'b001000,
        S_ROUND = 6'b010000,
        S_CLEAR = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]                 factor_reg, factor_next;
    logic [6:0]                 taps_reg, taps_next;
    logic                       align_reg, align_next;
    logic [TAPS_W-1:0]          teff_reg, teff_next;
    logic                       flush_reg, flush_next;
    logic                       first_reg, first_next;
    logic                       started_reg, started_next;
    logic [SLOT_W-1:0]          slots_reg, slots_next;
    logic [DROP_W-1:0]          drop_reg, drop_next;
    logic [IDX_W-1:0]           cnt_reg, cnt_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                       ovalid_reg, ovalid_next;
    logic signed [SAMPLE_W-1:0] osample_reg, osample_next;
    logic                       olast_reg, olast_next;
    logic                       oend_reg, oend_next;

    logic in_acc;
    logic out_free;
    logic last_slot;
    int   f_int;
    int   t_int;
    int   d_int;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !ovalid_reg || !out_stall;
    assign last_slot = (slots_reg == SLOT_W'(1));

    // effective factor, tap count and alignment delay from the registers
    always_comb
    begin
        f_int = int'(factor_reg);
        if (f_int < 1)
        begin
            f_int = 1;
        end
        if (f_int > MAX_FACTOR)
        begin
            f_int = MAX_FACTOR;
        end
        t_int = int'(taps_reg);
        if (t_int < 1)
        begin
            t_int = 1;
        end
        if (t_int > MAX_TAPS)
        begin
            t_int = MAX_TAPS;
        end
        d_int = align_reg ? ((t_int - 1) >> 1) : 0;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        factor_next  = factor_reg;
        taps_next    = taps_reg;
        align_next   = align_reg;
        teff_next    = teff_reg;
        flush_next   = flush_reg;
        first_next   = first_reg;
        started_next = started_reg;
        slots_next   = slots_reg;
        drop_next    = drop_reg;
        cnt_next     = cnt_reg;
        sample_next  = sample_reg;
        osample_next = osample_reg;
        olast_next   = olast_reg;
        oend_next    = oend_reg;
        ovalid_next  = ovalid_reg && out_stall;
        cell_cmd     = '0;
        mac_cmd      = '0;
        tap_wr       = 1'b0;
        slot_value   = first_reg ? sample_reg : '0;

        // register writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FACTOR: factor_next = cfg_data[3:0];
                CFG_TAPS:   taps_next   = cfg_data[6:0];
                CFG_ALIGN:  align_next  = cfg_data[0];
                default:    ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    teff_next = TAPS_W'(t_int);
                    unique case (kind)
                        KIND_SAMPLE:
                        begin
                            if (!started_reg)
                            begin
                                started_next = 1'b1;
                                drop_next    = DROP_W'(d_int);
                            end
                            slots_next  = SLOT_W'(f_int);
                            first_next  = 1'b1;
                            flush_next  = 1'b0;
                            sample_next = sample_in;
                            state_next  = S_SHIFT;
                        end
                        KIND_FLUSH:
                        begin
                            first_next = 1'b0;
                            flush_next = 1'b1;
                            slots_next = SLOT_W'(d_int);
                            if (started_reg && d_int != 0)
                            begin
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                state_next = S_CLEAR;
                            end
                        end
                        KIND_TAP:
                        begin
                            tap_wr = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_SHIFT:
            begin
                cell_cmd.shift = 1'b1;
                mac_cmd.clear  = 1'b1;
                first_next     = 1'b0;
                cnt_next       = '0;
                state_next     = S_MAC;
            end
            S_MAC:
            begin
                cell_cmd.rotate = 1'b1;
                mac_cmd.step    = 1'b1;
                mac_cmd.use_tap = (TAPS_W'(cnt_reg) < teff_reg);
                cnt_next        = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(MAX_TAPS - 1))
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                mac_cmd.step = 1'b1;
                state_next   = S_ROUND;
            end
            S_ROUND:
            begin
                if (drop_reg != '0 || out_free)
                begin
                    if (drop_reg != '0)
                    begin
                        drop_next = drop_reg - DROP_W'(1);
                    end
                    else
                    begin
                        ovalid_next  = 1'b1;
                        osample_next = mac_result;
                        olast_next   = last_slot;
                        oend_next    = last_slot && flush_reg;
                    end
                    if (last_slot)
                    begin
                        state_next = flush_reg ? S_CLEAR : S_IDLE;
                    end
                    else
                    begin
                        slots_next = slots_reg - SLOT_W'(1);
                        state_next = S_SHIFT;
                    end
                end
            end
            S_CLEAR:
            begin
                cell_cmd.clear = 1'b1;
                drop_next      = '0;
                started_next   = 1'b0;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            factor_reg  <= 4'd1;
            taps_reg    <= 7'd1;
            align_reg   <= 1'b0;
            started_reg <= 1'b0;
            drop_reg    <= '0;
            ovalid_reg  <= 1'b0;
            first_reg   <= 1'b0;
            flush_reg   <= 1'b0;
            slots_reg   <= '0;
            cnt_reg     <= '0;
            teff_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            factor_reg  <= factor_next;
            taps_reg    <= taps_next;
            align_reg   <= align_next;
            started_reg <= started_next;
            drop_reg    <= drop_next;
            ovalid_reg  <= ovalid_next;
            first_reg   <= first_next;
            flush_reg   <= flush_next;
            slots_reg   <= slots_next;
            cnt_reg     <= cnt_next;
            teff_reg    <= teff_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        osample_reg <= osample_next;
        olast_reg   <= olast_next;
        oend_reg    <= oend_next;
    end

    assign out_valid    = ovalid_reg;
    assign sample_out   = osample_reg;
    assign last_of_run  = olast_reg;
    assign end_of_block = oend_reg;

endmodule

// ----- rtl/fir_interpolator_top.sv -----
// Zero-insertion FIR interpolator. Each output slot is computed in turn: a shift step moves
// the new slot into a ring of 64 cells (one history sample and one tap each), the rotate
// steps turn the ring past the single 16x18 multiplier at its head while the products are
// accumulated, a sum step drains the product register and a rounding step hands the beat to
// the output register. A sample item computes factor slots, a flush computes
// floor((taps-1)/2) slots in aligned mode with a block open (none otherwise) before clearing
// the ring, and a tap write is taken without leaving the idle state. The output register holds a
// finished beat while the next slot is being computed; a beat still waiting there when the next
// kept slot is rounded holds the sequencer in its rounding state until the receiver takes it.
// depends on fi_pkg, fi_cell, fi_mac and fi_ctrl
module fir_interpolator_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [fi_pkg::KIND_W-1:0]          kind,
    input  logic signed [fi_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [fi_pkg::TIDX_W-1:0]          tap_index,
    input  logic signed [fi_pkg::TAP_W-1:0]    tap_value,
    input  logic                               cfg_we,
    input  logic [fi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fi_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [fi_pkg::SAMPLE_W-1:0] sample_out,
    output logic                               last_of_run,
    output logic                               end_of_block
);
    import fi_pkg::*;

    cell_cmd_t                  cell_cmd;
    mac_cmd_t                   mac_cmd;
    logic signed [SAMPLE_W-1:0] slot_value;
    logic signed [SAMPLE_W-1:0] mac_result;
    logic                       tap_wr;

    logic signed [SAMPLE_W-1:0] hist_w [MAX_TAPS];
    logic signed [TAP_W-1:0]    tap_w  [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] left_w [MAX_TAPS];
    logic                       we_w   [MAX_TAPS];

    // sequencer
    fi_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .sample_in    (sample_in),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mac_result   (mac_result),
        .cell_cmd     (cell_cmd),
        .mac_cmd      (mac_cmd),
        .slot_value   (slot_value),
        .tap_wr       (tap_wr),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_out   (sample_out),
        .last_of_run  (last_of_run),
        .end_of_block (end_of_block)
    );

    // ring of cells, cell 0 holds the newest sample and faces the multiplier
    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        localparam int NEXT = (k + 1) % MAX_TAPS;

        if (k == 0)
        begin : g_head
            assign left_w[k] = slot_value;
        end
        else
        begin : g_body
            assign left_w[k] = hist_w[k-1];
        end

        assign we_w[k] = tap_wr && (int'(tap_index) == k);

        fi_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cell_cmd),
            .tap_we     (we_w[k]),
            .tap_wdata  (tap_value),
            .hist_left  (left_w[k]),
            .hist_right (hist_w[NEXT]),
            .tap_right  (tap_w[NEXT]),
            .hist       (hist_w[k]),
            .tap        (tap_w[k])
        );
    end

    // multiply-accumulate at the head of the ring
    fi_mac u_mac (
        .clk    (clk),
        .cmd    (mac_cmd),
        .hist   (hist_w[0]),
        .tap    (tap_w[0]),
        .result (mac_result)
    );

endmodule

// ----- rtl/fi_checker.sv -----
// fi_checker: port-level checks of the fir interpolator, bound to its top level
// depends on fi_pkg and fir_interpolator_top
module fi_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic [fi_pkg::KIND_W-1:0]          kind,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [fi_pkg::SAMPLE_W-1:0] sample_out,
    input logic                               last_of_run,
    input logic                               end_of_block
);
    import fi_pkg::*;

    // a flush's end mark always sits on the final beat of its run
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_block |-> last_of_run)
        else $error("end_of_block without last_of_run");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out)
            && $stable(last_of_run) && $stable(end_of_block))
        else $error("stalled output beat changed");

    // an accepted sample keeps the block busy while it is filtered
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == KIND_SAMPLE |=> in_stall)
        else $error("input not stalled after a sample beat");

    // a tap write does not stall the input afterwards
    a_tap_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == KIND_TAP |=> !in_stall)
        else $error("input stalled after a tap write");

endmodule

bind fir_interpolator_top fi_checker u_fi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out),
    .last_of_run  (last_of_run),
    .end_of_block (end_of_block)
);
